// ===== hw/rtl/lagc_pkg.sv =====
// Shared types, constants and helpers for the table-driven gain controller.
// Used by lagc_step, lagc_ctrl and lut_agc_gain_controller_core; no dependencies.

package lagc_pkg;

  // Stream payload widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 80;
  localparam int CMD_W       = 2;

  // Settle counter width covers the allowed settle lengths of one to three ticks
  localparam int SETTLE_W              = 2;
  localparam int SETTLE_COUNT_DEFAULT  = 1;

  // Command codes carried on tuser
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SYNC    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_SETTLE = 2'd1,
    MODE_SEEK   = 2'd2
  } mode_t;

  // Gain range
  localparam logic [7:0] GAIN_MIN           = 8'd2;
  localparam logic [7:0] GAIN_LIMIT_DEFAULT = 8'd81;

  // Carrier loss detection
  localparam logic [7:0]  QUAL_NO_CARRIER = 8'd18;
  localparam logic [9:0]  ORIGIN_LOST     = 10'd650;
  localparam logic [7:0]  LOST_TICKS      = 8'd3;

  // Deadband on the clamped power median
  localparam logic [14:0] BAND_LO   = 15'd19;
  localparam logic [14:0] BAND_HI   = 15'd25;
  localparam logic [9:0]  CLIP_BAND = 10'd20;

  // Trim learning at the end of a settle wait
  localparam logic [14:0]       TRIM_LOW_P  = 15'd16;
  localparam logic [14:0]       TRIM_HIGH_P = 15'd28;
  localparam logic signed [3:0] TRIM_MAX    = 4'sd4;
  localparam logic signed [3:0] TRIM_MIN    = -4'sd4;

  // Emergency cuts
  localparam logic [14:0]       CUT_HARD_P = 15'd44;
  localparam logic [14:0]       CUT_SOFT_P = 15'd35;
  localparam logic [9:0]        CLIP_CUT   = 10'd80;
  localparam logic signed [5:0] CUT_HARD   = -6'sd14;
  localparam logic signed [5:0] CUT_SOFT   = -6'sd8;

  // Correction table and classification
  localparam int               LUT_DEPTH  = 46;
  localparam logic [14:0]      LUT_LAST   = 15'd45;
  localparam logic [7:0]       QUAL_AUTH  = 8'd50;
  localparam logic [9:0]       ORIGIN_AUTH = 10'd350;
  localparam logic signed [7:0] RSSI_MIN  = -8'sd100;
  localparam logic signed [7:0] RSSI_MAX  = -8'sd10;

  // Level estimate: base level plus gain minus distance from band centre
  localparam logic signed [17:0] EST_BASE    = -18'sd90;
  localparam logic signed [17:0] BAND_CENTRE = 18'sd22;
  localparam logic signed [17:0] EST_MAX     = 18'sd32767;
  localparam logic signed [15:0] LEVEL_RESET = -16'sd127;

  // Slew limits while tracking
  localparam logic [14:0]        SLEW_P    = 15'd8;
  localparam logic signed [10:0] SLEW_UP   = 11'sd4;
  localparam logic signed [10:0] SLEW_DOWN = -11'sd6;

  localparam logic signed [5:0] LUT_DELTA [LUT_DEPTH] = '{
    6'sd0,  6'sd16, 6'sd13, 6'sd11, 6'sd9,  6'sd8,  6'sd7,  6'sd6,  6'sd5,  6'sd5,
    6'sd4,  6'sd4,  6'sd3,  6'sd3,  6'sd2,  6'sd2,  6'sd2,  6'sd1,  6'sd1,  6'sd0,
    6'sd0,  6'sd0,  6'sd0,  6'sd0,  6'sd0,  6'sd0,  -6'sd1, -6'sd1, -6'sd1, -6'sd1,
    -6'sd2, -6'sd2, -6'sd2, -6'sd2, -6'sd2, -6'sd2, -6'sd3, -6'sd3, -6'sd3, -6'sd3,
    -6'sd3, -6'sd3, -6'sd3, -6'sd4, -6'sd4, -6'sd4
  };

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic signed [15:0]  power_median;
    logic [7:0]          phase_quality;
    logic [9:0]          origin_rate;
    logic [9:0]          clip_rate;
    logic [7:0]          fallback_gain;
    logic                rssi_ok;
    logic signed [7:0]   rssi_level;
    logic [7:0]          gain_value;
  } item_t;

  typedef struct packed {
    logic [7:0]          gain;
    logic [7:0]          goal_gain;
    logic [1:0]          mode;
    logic signed [5:0]   last_step;
    logic signed [3:0]   trim;
    logic signed [15:0]  input_estimate;
    logic [15:0]         write_count;
    logic [15:0]         hold_entry_count;
  } result_t;

  typedef struct packed {
    logic [7:0]          cur_gain;
    logic [7:0]          tgt_gain;
    mode_t               mode;
    logic [SETTLE_W-1:0] settle_left;
    logic signed [3:0]   cal_trim;
    logic [7:0]          lost_count;
    logic [15:0]         hold_run;
    logic signed [5:0]   step_taken;
    logic signed [15:0]  level_est;
    logic [15:0]         writes_done;
    logic [15:0]         holds_reached;
  } state_t;

  // Clamp a requested gain to GAIN_MIN..hi; below GAIN_MIN always wins
  function automatic logic [7:0] limit_gain(input logic signed [10:0] g,
                                            input logic [7:0] hi);
    logic signed [10:0] hi_s;
    hi_s = signed'({3'b000, hi});
    if (g < signed'({3'b000, GAIN_MIN})) begin
      return GAIN_MIN;
    end else if (g > hi_s) begin
      return hi;
    end else begin
      return g[7:0];
    end
  endfunction

endpackage

// ===== hw/rtl/lut_agc_gain_controller_core.sv =====
// Top level of the table-driven gain controller: stream ports, input and
// result registers, gain limit register. Depends on lagc_pkg and lagc_ctrl.

// While the output is not stalled the block takes one command per clock cycle;
// it returns exactly one result per command: the command is captured in an
// input register, the whole tick, sync or restart decision is made in one pass
// of logic against the held controller state, and the result lands in an output
// register together with the state update. With the output free, s_tready stays
// high and a command may follow in every cycle; a stalled output holds one
// result and one waiting command. The gain limit is written through cfg_we and
// cfg_wdata (zero selects a limit of 81) and should only change while idle.

module lut_agc_gain_controller_core import lagc_pkg::*; #(
  parameter int SETTLE_COUNT = SETTLE_COUNT_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata,     // highest gain index, zero for default
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // from bit 0: power_median[16], phase_quality[8], origin_rate[10],
  // clip_rate[10], fallback_gain[8], rssi_ok[1], rssi_level[8],
  // gain_value[8], zero padding[3]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [CMD_W-1:0]       s_tuser,       // command
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // from bit 0: gain[8], goal_gain[8], mode[2], last_step[6], trim[4],
  // input_estimate[16], write_count[16], hold_entry_count[16], zero padding[4]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic       cap_set;
  logic [7:0] gain_cap;
  logic [7:0] gain_limit;
  logic       in_valid;
  item_t      in_item;
  item_t      s_item;
  logic       advance;
  logic       fire;
  result_t    res_next;
  result_t    out_res;
  logic       out_valid;

  // Hold the gain limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_cap <= '0;
    end else if (cfg_we) begin
      gain_cap <= cfg_wdata;
    end
  end

  assign cap_set    = (gain_cap != '0);
  assign gain_limit = cap_set ? gain_cap : GAIN_LIMIT_DEFAULT;

  // Unpack the incoming transaction
  always_comb begin
    s_item.command       = s_tuser;
    s_item.power_median  = s_tdata[15:0];
    s_item.phase_quality = s_tdata[23:16];
    s_item.origin_rate   = s_tdata[33:24];
    s_item.clip_rate     = s_tdata[43:34];
    s_item.fallback_gain = s_tdata[51:44];
    s_item.rssi_ok       = s_tdata[52];
    s_item.rssi_level    = s_tdata[60:53];
    s_item.gain_value    = s_tdata[68:61];
  end

  // Stage handshake: the input register drains whenever the output can take a result
  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // Capture a command into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= s_item;
    end
  end

  lagc_ctrl #(
    .SETTLE_COUNT (SETTLE_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (in_item),
    .gain_limit (gain_limit),
    .res_next   (res_next)
  );

  // Load the result register; hold it while the output stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_res.hold_entry_count, out_res.write_count,
                     out_res.input_estimate, out_res.trim, out_res.last_step,
                     out_res.mode, out_res.goal_gain, out_res.gain};

endmodule

// ===== hw/rtl/lagc_step.sv =====
// Single-pass decision logic: next controller state for one command.
// Depends on lagc_pkg; purely combinational, used inside lagc_ctrl.

module lagc_step import lagc_pkg::*; #(
  parameter int SETTLE_COUNT = SETTLE_COUNT_DEFAULT
) (
  input  state_t     st,
  input  item_t      item,
  input  logic [7:0] gain_limit,
  output state_t     nx
);

  localparam logic [SETTLE_W-1:0] SETTLE_LOAD = SETTLE_W'(SETTLE_COUNT);

  logic [14:0]         p;
  logic signed [10:0]  cur_s;
  logic                carrier_lost;
  logic                in_band;
  logic [7:0]          lost_inc;
  logic [15:0]         hold_inc;
  logic [SETTLE_W-1:0] settle_dec;
  logic                cut_req;
  logic signed [5:0]   cut_amt;
  logic [7:0]          cut_next;
  logic [5:0]          lut_idx;
  logic signed [6:0]   delta_w;
  logic signed [5:0]   delta;
  logic                authentic;
  logic                rssi_use;
  logic signed [17:0]  est_raw;
  logic signed [15:0]  est_sat;
  logic [7:0]          desired;
  logic signed [10:0]  step_raw;
  logic signed [10:0]  step_lim;
  logic [7:0]          track_next;
  logic [7:0]          sync_gain;

  // Decode the tick observation
  always_comb begin
    p            = item.power_median[15] ? '0 : item.power_median[14:0];
    cur_s        = signed'({3'b000, st.cur_gain});
    carrier_lost = (item.phase_quality < QUAL_NO_CARRIER) &&
                   (item.origin_rate >= ORIGIN_LOST);
    in_band      = (p >= BAND_LO) && (p <= BAND_HI) && (item.clip_rate < CLIP_BAND);
    lost_inc     = (st.lost_count != 8'hFF) ? st.lost_count + 8'd1 : st.lost_count;
    hold_inc     = (st.hold_run != 16'hFFFF) ? st.hold_run + 16'd1 : st.hold_run;
    settle_dec   = st.settle_left - SETTLE_W'(1);
    authentic    = (item.phase_quality >= QUAL_AUTH) &&
                   (item.origin_rate <= ORIGIN_AUTH);
    rssi_use     = item.rssi_ok && (item.rssi_level >= RSSI_MIN) &&
                   (item.rssi_level <= RSSI_MAX) && authentic;
    sync_gain    = limit_gain(signed'({3'b000, item.gain_value}), gain_limit);
  end

  // Emergency cut candidate
  always_comb begin
    cut_req  = (p > CUT_HARD_P) ||
               ((item.clip_rate >= CLIP_CUT) && (p > CUT_SOFT_P));
    cut_amt  = (p > CUT_HARD_P) ? CUT_HARD : CUT_SOFT;
    cut_next = limit_gain(cur_s + {{5{cut_amt[5]}}, cut_amt}, gain_limit);
  end

  // Table correction, level estimate and slew limiting
  always_comb begin
    lut_idx    = (p > LUT_LAST) ? LUT_LAST[5:0] : p[5:0];
    delta_w    = {LUT_DELTA[lut_idx][5], LUT_DELTA[lut_idx]} +
                 {{3{st.cal_trim[3]}}, st.cal_trim};
    delta      = delta_w[5:0];
    est_raw    = signed'({3'b000, p}) + signed'({10'b0, st.cur_gain}) + EST_BASE - BAND_CENTRE;
    est_sat    = (est_raw > EST_MAX) ? EST_MAX[15:0] : est_raw[15:0];
    desired    = limit_gain(cur_s + {{5{delta[5]}}, delta}, gain_limit);
    step_raw   = signed'({3'b000, desired}) - cur_s;
    step_lim   = step_raw;
    if ((p >= SLEW_P) || authentic || (st.hold_run != '0)) begin
      if (step_raw > SLEW_UP) begin
        step_lim = SLEW_UP;
      end else if (step_raw < SLEW_DOWN) begin
        step_lim = SLEW_DOWN;
      end
    end
    track_next = limit_gain(cur_s + step_lim, gain_limit);
  end

  // Next state
  always_comb begin
    nx = st;
    case (item.command)
      CMD_TICK: begin
        if (carrier_lost) begin
          nx.lost_count  = lost_inc;
          nx.cal_trim    = '0;
          nx.settle_left = '0;
          nx.mode        = MODE_SEEK;
          if ((lost_inc >= LOST_TICKS) && (item.fallback_gain != '0)) begin
            nx.cur_gain = limit_gain(signed'({3'b000, item.fallback_gain}), gain_limit);
            nx.tgt_gain = nx.cur_gain;
          end
        end else begin
          nx.lost_count = '0;
          if (st.settle_left != '0) begin
            // Count down the settle wait and learn the trim at its end
            nx.settle_left = settle_dec;
            if (settle_dec == '0) begin
              if (in_band) begin
                nx.mode          = MODE_HOLD;
                nx.hold_run      = 16'd1;
                nx.holds_reached = st.holds_reached + 16'd1;
              end else if ((p < TRIM_LOW_P) && (st.cal_trim < TRIM_MAX)) begin
                nx.cal_trim = st.cal_trim + 4'sd1;
                nx.mode     = MODE_SEEK;
              end else if ((p > TRIM_HIGH_P) && (st.cal_trim > TRIM_MIN)) begin
                nx.cal_trim = st.cal_trim - 4'sd1;
                nx.mode     = MODE_SEEK;
              end else begin
                nx.mode = MODE_HOLD;
              end
            end
          end else if (in_band) begin
            nx.mode     = MODE_HOLD;
            nx.hold_run = hold_inc;
          end else if (cut_req && (cut_next != st.cur_gain)) begin
            nx.cur_gain    = cut_next;
            nx.tgt_gain    = cut_next;
            nx.settle_left = SETTLE_LOAD;
            nx.mode        = MODE_SETTLE;
            nx.step_taken  = cut_amt;
            nx.writes_done = st.writes_done + 16'd1;
          end else begin
            // Track with the table correction
            nx.level_est  = rssi_use ? 16'(item.rssi_level) : est_sat;
            nx.step_taken = delta;
            if (delta != '0) begin
              nx.tgt_gain = desired;
            end
            if ((delta != '0) && (track_next != st.cur_gain)) begin
              nx.cur_gain    = track_next;
              nx.settle_left = SETTLE_LOAD;
              nx.mode        = MODE_SETTLE;
              nx.hold_run    = '0;
              nx.writes_done = st.writes_done + 16'd1;
            end else begin
              nx.mode     = MODE_HOLD;
              nx.hold_run = hold_inc;
            end
          end
        end
      end
      CMD_SYNC: begin
        if (sync_gain != st.cur_gain) begin
          nx.cur_gain    = sync_gain;
          nx.tgt_gain    = sync_gain;
          nx.settle_left = SETTLE_LOAD;
          nx.mode        = MODE_SETTLE;
        end
      end
      CMD_RESTART: begin
        nx.cur_gain      = sync_gain;
        nx.tgt_gain      = sync_gain;
        nx.mode          = MODE_SEEK;
        nx.settle_left   = '0;
        nx.cal_trim      = '0;
        nx.lost_count    = '0;
        nx.hold_run      = '0;
        nx.step_taken    = '0;
        nx.level_est     = LEVEL_RESET;
        nx.writes_done   = '0;
        nx.holds_reached = '0;
      end
      default: begin
        nx = st;
      end
    endcase
  end

endmodule

// ===== hw/rtl/lagc_ctrl.sv =====
// Controller state registers and result formation around lagc_step.
// Depends on lagc_pkg and lagc_step.

module lagc_ctrl import lagc_pkg::*; #(
  parameter int SETTLE_COUNT = SETTLE_COUNT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  item_t      item,
  input  logic [7:0] gain_limit,
  output result_t    res_next
);

  state_t st;
  state_t st_next;

  lagc_step #(
    .SETTLE_COUNT (SETTLE_COUNT)
  ) u_step (
    .st         (st),
    .item       (item),
    .gain_limit (gain_limit),
    .nx         (st_next)
  );

  // Advance the state on each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st.cur_gain      <= GAIN_MIN;
      st.tgt_gain      <= GAIN_MIN;
      st.mode          <= MODE_SEEK;
      st.settle_left   <= '0;
      st.cal_trim      <= '0;
      st.lost_count    <= '0;
      st.hold_run      <= '0;
      st.step_taken    <= '0;
      st.level_est     <= LEVEL_RESET;
      st.writes_done   <= '0;
      st.holds_reached <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // Report the state after this command
  always_comb begin
    res_next.gain             = st_next.cur_gain;
    res_next.goal_gain        = st_next.tgt_gain;
    res_next.mode             = st_next.mode;
    res_next.last_step        = st_next.step_taken;
    res_next.trim             = st_next.cal_trim;
    res_next.input_estimate   = st_next.level_est;
    res_next.write_count      = st_next.writes_done;
    res_next.hold_entry_count = st_next.holds_reached;
  end

  a_gain_nonzero : assert property (@(posedge clk) disable iff (rst)
    st.cur_gain != '0)
    else $error("current gain reached zero");

  a_trim_range : assert property (@(posedge clk) disable iff (rst)
    (st.cal_trim >= TRIM_MIN) && (st.cal_trim <= TRIM_MAX))
    else $error("trim outside its learning range");

  a_settle_bound : assert property (@(posedge clk) disable iff (rst)
    st.settle_left <= SETTLE_W'(SETTLE_COUNT))
    else $error("settle counter above its load value");

  a_settle_mode : assert property (@(posedge clk) disable iff (rst)
    (st.settle_left != '0) == (st.mode == MODE_SETTLE))
    else $error("settle mode and settle counter disagree");

  a_state_hold : assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(st))
    else $error("state changed without a transaction");

endmodule

// ===== dv/tb_lut_agc_gain_controller_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lut_agc_gain_controller_core: drives command streams,
// predicts every result in a scoreboard class and checks the result stream.
// Depends on lagc_pkg and the controller RTL only.

module tb_lut_agc_gain_controller_core;
  import lagc_pkg::*;

  localparam int SETTLE_LEN   = SETTLE_COUNT_DEFAULT;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASE_ITEMS  = 210;
  localparam int LOSS_BURST   = 260;
  localparam int N_PHASES     = 7;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  // Predicts the controller state per accepted command and checks each report
  class agc_scoreboard;
    bit [7:0] limit_reg;
    int       settle_len;
    int       cur_gain, tgt_gain, settle_left, trim_steps, lost_ticks, hold_run;
    int       last_delta, level_dbm, writes, holds;
    mode_t    mode;
    int       corr[46];
    result_t  reports_due[$];
    int       mismatches, checked, n_tick, n_sync, n_restart, n_none;

    function new(int settle);
      settle_len = settle;
      corr = '{0, 16, 13, 11, 9, 8, 7, 6, 5, 5,
               4, 4, 3, 3, 2, 2, 2, 1, 1, 0,
               0, 0, 0, 0, 0, 0, -1, -1, -1, -1,
               -2, -2, -2, -2, -2, -2, -3, -3, -3, -3,
               -3, -3, -3, -4, -4, -4};
      mismatches = 0;
      checked    = 0;
      n_tick     = 0;
      n_sync     = 0;
      n_restart  = 0;
      n_none     = 0;
      limit_reg  = 8'd0;
      clear_state();
    endfunction

    function int fit_gain(int g);
      int hi;
      hi = (limit_reg != 0) ? int'(limit_reg) : 81;
      if (g < 2) return 2;
      if (g > hi) return hi;
      return g;
    endfunction

    function void clear_state();
      cur_gain    = fit_gain(0);
      tgt_gain    = cur_gain;
      mode        = MODE_SEEK;
      settle_left = 0;
      trim_steps  = 0;
      lost_ticks  = 0;
      hold_run    = 0;
      last_delta  = 0;
      level_dbm   = -127;
      writes      = 0;
      holds       = 0;
    endfunction

    function void set_limit(bit [7:0] v);
      limit_reg = v;
    endfunction

    function void bump_hold();
      mode = MODE_HOLD;
      if (hold_run < 65535) hold_run++;
    endfunction

    function bit try_cut(int cut);
      int nxt;
      nxt = fit_gain(cur_gain + cut);
      if (nxt == cur_gain) return 1'b0;
      cur_gain    = nxt;
      tgt_gain    = nxt;
      settle_left = settle_len;
      mode        = MODE_SETTLE;
      last_delta  = cut;
      writes      = (writes + 1) & 16'hFFFF;
      return 1'b1;
    endfunction

    // One control tick: carrier loss, settle wait, deadband, cuts, table step
    function void step_tick(item_t it);
      int p, q, org, clip, fb, rssi, delta, est, desired, stp, nxt;
      bit rok, in_band, authentic;
      p    = int'($signed(it.power_median));
      q    = it.phase_quality;
      org  = it.origin_rate;
      clip = it.clip_rate;
      fb   = it.fallback_gain;
      rok  = it.rssi_ok;
      rssi = int'($signed(it.rssi_level));
      if (p < 0) p = 0;

      if (q < 18 && org >= 650) begin
        if (lost_ticks < 255) lost_ticks++;
        trim_steps  = 0;
        settle_left = 0;
        mode        = MODE_SEEK;
        if (lost_ticks >= 3 && fb != 0) begin
          tgt_gain = fit_gain(fb);
          cur_gain = tgt_gain;
        end
        return;
      end
      lost_ticks = 0;

      in_band = p >= 19 && p <= 25 && clip < 20;

      if (settle_left > 0) begin
        settle_left--;
        if (settle_left == 0) begin
          if (in_band) begin
            mode     = MODE_HOLD;
            hold_run = 1;
            holds    = (holds + 1) & 16'hFFFF;
          end else if (p < 16 && trim_steps < 4) begin
            trim_steps++;
            mode = MODE_SEEK;
          end else if (p > 28 && trim_steps > -4) begin
            trim_steps--;
            mode = MODE_SEEK;
          end else begin
            mode = MODE_HOLD;
          end
        end
        return;
      end

      if (in_band) begin
        bump_hold();
        return;
      end

      if (p > 44) begin
        if (try_cut(-14)) return;
      end else if (clip >= 80 && p > 35) begin
        if (try_cut(-8)) return;
      end

      delta     = corr[(p > 45) ? 45 : p] + trim_steps;
      authentic = q >= 50 && org <= 350;
      if (rok && rssi >= -100 && rssi <= -10 && authentic) begin
        level_dbm = rssi;
      end else begin
        est = -90 + cur_gain - (22 - p);
        if (est > 32767) est = 32767;
        level_dbm = est;
      end
      last_delta = delta;

      if (delta != 0) begin
        desired  = fit_gain(cur_gain + delta);
        stp      = desired - cur_gain;
        tgt_gain = desired;
        // slew limit applies unless power is below 8, the tick is not authentic and no hold run is in progress
        if (p >= 8 || authentic || hold_run > 0) begin
          if (stp > 4) stp = 4;
          if (stp < -6) stp = -6;
        end
        nxt = fit_gain(cur_gain + stp);
        if (nxt != cur_gain) begin
          cur_gain    = nxt;
          settle_left = settle_len;
          mode        = MODE_SETTLE;
          hold_run    = 0;
          writes      = (writes + 1) & 16'hFFFF;
        end else begin
          bump_hold();
        end
      end else begin
        bump_hold();
      end
    endfunction

    // Advance the prediction for one accepted command and queue its report
    function void note_command(item_t it);
      result_t r;
      int g;
      case (it.command)
        CMD_TICK: begin
          n_tick++;
          step_tick(it);
        end
        CMD_SYNC: begin
          n_sync++;
          g = fit_gain(it.gain_value);
          if (g != cur_gain) begin
            cur_gain    = g;
            tgt_gain    = g;
            settle_left = settle_len;
            mode        = MODE_SETTLE;
          end
        end
        CMD_RESTART: begin
          n_restart++;
          clear_state();
          cur_gain = fit_gain(it.gain_value);
          tgt_gain = cur_gain;
        end
        default: n_none++;
      endcase
      r.gain             = 8'(cur_gain);
      r.goal_gain        = 8'(tgt_gain);
      r.mode             = mode;
      r.last_step        = 6'(last_delta);
      r.trim             = 4'(trim_steps);
      r.input_estimate   = 16'(level_dbm);
      r.write_count      = 16'(writes);
      r.hold_entry_count = 16'(holds);
      reports_due.push_back(r);
    endfunction

    function void cmp_field(string name, int want, int seen);
      if (want != seen) begin
        mismatches++;
        $error("report %0d: %s expected %0d, got %0d", checked, name, want, seen);
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (reports_due.size() == 0) begin
        mismatches++;
        $error("report with no command outstanding: gain %0d", got.gain);
        return;
      end
      want = reports_due.pop_front();
      cmp_field("gain", want.gain, got.gain);
      cmp_field("goal_gain", want.goal_gain, got.goal_gain);
      cmp_field("mode", want.mode, got.mode);
      cmp_field("last_step", want.last_step, got.last_step);
      cmp_field("trim", want.trim, got.trim);
      cmp_field("input_estimate", want.input_estimate, got.input_estimate);
      cmp_field("write_count", want.write_count, got.write_count);
      cmp_field("hold_entry_count", want.hold_entry_count, got.hold_entry_count);
      checked++;
    endfunction

    function int pending();
      return reports_due.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we;
  logic [7:0]             cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [CMD_W-1:0]       s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  agc_scoreboard sb;
  bit            tx_quiet = 1'b0;
  bit            rx_quiet = 1'b0;
  int            plant_level = -40;
  int            cycles = 0;

  lut_agc_gain_controller_core #(
    .SETTLE_COUNT(SETTLE_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_lut_agc_gain_controller_core: FAIL");
      $finish;
    end
  end

  function automatic int draw_wait(bit quiet);
    if (quiet) return 0;
    return int'($urandom_range(0, 15));
  endfunction

  function automatic item_t tick_item(int p, int q, int org, int clip, int fb,
                                      bit rok, int rssi);
    item_t it;
    it.command       = CMD_TICK;
    it.power_median  = 16'(p);
    it.phase_quality = 8'(q);
    it.origin_rate   = 10'(org);
    it.clip_rate     = 10'(clip);
    it.fallback_gain = 8'(fb);
    it.rssi_ok       = rok;
    it.rssi_level    = 8'(rssi);
    it.gain_value    = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Any command with arbitrary content
  function automatic item_t any_item(logic [CMD_W-1:0] cmd, int gv);
    item_t it;
    it = tick_item(int'($urandom_range(0, 65535)), int'($urandom_range(0, 255)),
                   int'($urandom_range(0, 1000)), int'($urandom_range(0, 1000)),
                   int'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   int'($urandom_range(0, 255)));
    it.command    = cmd;
    it.gain_value = 8'(gv);
    return it;
  endfunction

  function automatic item_t loss_item();
    return tick_item(int'($urandom_range(0, 65535)), int'($urandom_range(0, 17)),
                     int'($urandom_range(650, 1000)), int'($urandom_range(0, 1000)),
                     ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), int'($urandom_range(0, 255)));
  endfunction

  // Mostly closed-loop ticks whose power follows the predicted gain
  function automatic item_t random_item();
    int r, p, q, org, clip, rssi;
    r = int'($urandom_range(0, 99));
    if (r < 55) begin
      if ($urandom_range(0, 19) == 0) plant_level = int'($urandom_range(0, 100)) - 80;
      else plant_level = plant_level + int'($urandom_range(0, 6)) - 3;
      if (plant_level < -80) plant_level = -80;
      if (plant_level > 20) plant_level = 20;
      p    = plant_level + sb.cur_gain + int'($urandom_range(0, 4)) - 2;
      clip = ($urandom_range(0, 6) == 0) ? int'($urandom_range(80, 400))
                                         : int'($urandom_range(0, 25));
      q    = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 49))
                                         : int'($urandom_range(50, 255));
      org  = ($urandom_range(0, 4) == 0) ? int'($urandom_range(351, 1000))
                                         : int'($urandom_range(0, 350));
      rssi = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
                                         : int'($urandom_range(0, 90)) - 100;
      return tick_item(p, q, org, clip, int'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), rssi);
    end
    if (r < 65) begin
      return tick_item(int'($urandom_range(0, 60)), int'($urandom_range(0, 255)),
                       int'($urandom_range(0, 1000)), int'($urandom_range(0, 120)),
                       int'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       int'($urandom_range(0, 255)));
    end
    if (r < 72) return loss_item();
    if (r < 79) begin
      return any_item(CMD_SYNC, ($urandom_range(0, 1) == 1)
                      ? sb.cur_gain + int'($urandom_range(0, 6)) - 3
                      : int'($urandom_range(0, 255)));
    end
    if (r < 83) return any_item(CMD_RESTART, int'($urandom_range(0, 255)));
    if (r < 86) return any_item(CMD_NONE, int'($urandom_range(0, 255)));
    return any_item(CMD_W'($urandom_range(0, 3)), int'($urandom_range(0, 255)));
  endfunction

  // Offer one command and hold it until the block takes it
  task automatic send_item(input item_t it);
    int gap;
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.command;
    s_tdata  <= {3'b000, it.gain_value, it.rssi_level, it.rssi_ok, it.fallback_gain,
                 it.clip_rate, it.origin_rate, it.phase_quality,
                 it.power_median};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.note_command(it);
  endtask

  // Stop offering and wait for every outstanding report, then let the pipe empty
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= 8'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_limit(8'(v));
  endtask

  // Result side: random stalls, check each accepted transaction
  initial begin : result_sink
    int stall;
    logic [OUT_TDATA_W-1:0] d;
    result_t got;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = draw_wait(rx_quiet);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
      d                    = m_tdata;
      got.gain             = d[7:0];
      got.goal_gain        = d[15:8];
      got.mode             = d[17:16];
      got.last_step        = d[23:18];
      got.trim             = d[27:24];
      got.input_estimate   = d[43:28];
      got.write_count      = d[59:44];
      got.hold_entry_count = d[75:60];
      sb.check_report(got);
    end
  end

  // Stimulus: directed opening, then random phases under different gain limits
  initial begin : stimulus
    int limits[N_PHASES];
    int ph, n, k;
    cfg_we    = 1'b0;
    cfg_wdata = 8'd0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_TICK;
    sb = new(SETTLE_LEN);
    limits = '{0, 255, 1, 2, 60, 0, 0};
    limits[5] = int'($urandom_range(3, 254));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_limit(limits[0]);

    // restart at both ends of the gain range
    send_item(any_item(CMD_RESTART, 0));
    send_item(any_item(CMD_RESTART, 255));
    // negative power counts as zero; trusted RSSI sets the estimate
    send_item(tick_item(-32768, 255, 0, 0, 0, 1'b1, -50));
    // hard cut, then settle into the deadband and hold
    send_item(tick_item(32767, 0, 0, 0, 0, 1'b0, 0));
    send_item(tick_item(22, 100, 100, 0, 0, 1'b0, 0));
    send_item(tick_item(22, 100, 100, 0, 0, 1'b0, 0));
    // soft cut on clipping, settle ends low and raises the trim
    send_item(tick_item(40, 100, 100, 100, 0, 1'b0, 0));
    send_item(tick_item(10, 100, 100, 0, 0, 1'b0, 0));
    send_item(tick_item(5, 100, 100, 0, 0, 1'b1, -128));
    send_item(tick_item(30, 100, 100, 0, 0, 1'b0, 0));
    // carrier loss three times with a survival gain, then without one
    for (k = 0; k < 3; k++) send_item(tick_item(0, 0, 1000, 0, 255, 1'b0, 0));
    send_item(tick_item(0, 17, 650, 0, 0, 1'b0, 0));
    send_item(any_item(CMD_SYNC, 0));
    send_item(any_item(CMD_SYNC, 255));
    send_item(any_item(CMD_SYNC, 255));
    send_item(tick_item(-1, 255, 1000, 1000, 255, 1'b1, 127));
    send_item(any_item(CMD_NONE, 255));
    send_item(tick_item(3, 17, 649, 1000, 0, 1'b1, 127));
    send_item(tick_item(45, 50, 350, 0, 0, 1'b1, -10));
    // deadband edges
    send_item(tick_item(25, 60, 0, 19, 0, 1'b0, 0));
    send_item(tick_item(19, 60, 0, 20, 0, 1'b0, 0));
    // cut refused at the bottom of the range
    send_item(any_item(CMD_RESTART, 2));
    send_item(tick_item(60, 0, 0, 0, 0, 1'b1, -100));

    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        drain_results();
        write_limit(limits[ph]);
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 64 == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        // long carrier outage saturates the loss counter
        if (ph == 1 && n == 100)
          for (k = 0; k < LOSS_BURST; k++) send_item(loss_item());
        // hold off mid-phase until the block has answered everything
        if (ph == 3 && n == PHASE_ITEMS / 2) drain_results();
        send_item(random_item());
      end
    end
    drain_results();

    $display("Sent %0d ticks, %0d syncs, %0d restarts, %0d unused codes under %0d gain limits",
             sb.n_tick, sb.n_sync, sb.n_restart, sb.n_none, N_PHASES);
    $display("Checked %0d reports, %0d field mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_lut_agc_gain_controller_core: PASS");
    end else begin
      $display("tb_lut_agc_gain_controller_core: FAIL");
    end
    $finish;
  end

endmodule

// ===== lut_agc_gain_controller_core.f =====
hw/rtl/lagc_pkg.sv
hw/rtl/lagc_step.sv
hw/rtl/lagc_ctrl.sv
hw/rtl/lut_agc_gain_controller_core.sv
dv/tb_lut_agc_gain_controller_core.sv
